>>> rtl/segment_rect_collision_check_macros.svh
// Assertion macros for the segment-rectangle collision checker
`ifndef SEGMENT_RECT_COLLISION_CHECK_MACROS_SVH
`define SEGMENT_RECT_COLLISION_CHECK_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SRCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment_rect_collision_check: assertion failed");
`define SRCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segment_rect_collision_check: assertion failed");
`else
`define SRCC_ASSERT_NOW(label, ante, cons)
`define SRCC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/scrc_pkg.sv
// Types and constants of the segment-rectangle collision checker
`timescale 1ns / 1ps
package scrc_pkg;

  localparam int MAX_OBSTACLES = 16;
  localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);
  localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;

  localparam int COORD_W = 16;
  localparam int SIZE_W = 15;
  localparam int EDGE_W = 17;
  localparam int DIFF_W = 18;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W = PROD_W + 1;
  localparam int OBS_CNT_W = 5;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = SIZE_W;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y = 1'b1;
  localparam logic [SIZE_W-1:0] MAP_SIZE_RESET = 15'd50;

  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
  } rect_t;

  localparam int RECT_W = $bits(rect_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_DIFF,
    S_MUL,
    S_SUM,
    S_EVAL
  } state_t;

endpackage

>>> rtl/segment_rect_collision_check.sv
// Top level of the segment-rectangle collision checker
//
// Usage: a request is taken at a rising edge with start high and busy low.
// action selects add (store rect_x/rect_y/rect_w/rect_h as an obstacle) or
// check (test the segment point_a..point_b against map and obstacles).
// Every request gives one result: done is high for exactly one cycle with
// path_clear, table_full and obstacle_count valid in that cycle.
// Add: result in the cycle after the request; busy stays low. A full table
// refuses the add and raises table_full.
// Check: result in the cycle after the request when an endpoint is outside
// the map or the table is empty; otherwise each stored rectangle goes through
// RAM read, edge setup, four products on the one shared 18x18 multiplier,
// four sums on the one shared adder and a decision, stopping at the first
// rectangle that blocks. busy is high while the rectangles are checked.
// Configuration: cfg_write/cfg_index/cfg_data write the map extent in x (0)
// or in y (1), one extent per write; write only while idle.
// Reset: the table is empty, both map sizes are 50. The receiver cannot
// stall, so results are never held.
`timescale 1ns / 1ps
`include "segment_rect_collision_check_macros.svh"
module segment_rect_collision_check (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   action,
  input  logic signed [scrc_pkg::COORD_W-1:0]    rect_x,
  input  logic signed [scrc_pkg::COORD_W-1:0]    rect_y,
  input  logic [scrc_pkg::SIZE_W-1:0]            rect_w,
  input  logic [scrc_pkg::SIZE_W-1:0]            rect_h,
  input  logic signed [scrc_pkg::COORD_W-1:0]    point_ax,
  input  logic signed [scrc_pkg::COORD_W-1:0]    point_ay,
  input  logic signed [scrc_pkg::COORD_W-1:0]    point_bx,
  input  logic signed [scrc_pkg::COORD_W-1:0]    point_by,
  input  logic                                   cfg_write,
  input  logic [scrc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [scrc_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                   done,
  output logic                                   path_clear,
  output logic                                   table_full,
  output logic [scrc_pkg::OBS_CNT_W-1:0]         obstacle_count
);
  import scrc_pkg::*;

  state_t state, state_next;
  logic [CNT_W-1:0] count, count_inc, idx, idx_inc;
  logic [1:0] step;
  logic [SIZE_W-1:0] extent_x, extent_y;

  logic signed [COORD_W-1:0] ax, ay, bx, by, l, b;
  logic signed [EDGE_W-1:0] dx, dy, rt, t;
  logic signed [DIFF_W-1:0] d_axl, d_axr, d_tay, d_bay;
  logic w_nz, h_nz, cont_hit, t_btw, b_btw, l_btw, r_btw;
  logic signed [PROD_W-1:0] p1, p2, p3, p4, prod;
  logic signed [DIFF_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] sum_a, sum_b;
  logic signed [SUM_W-1:0] sum;
  logic [3:0] s_ge, s_le;

  rect_t ram_wdata, ram_rdata;
  logic ram_we, table_is_full, in_map_ok, last, rect_hit;
  logic top_x, bot_x, left_x, right_x, dx_pos, dy_pos, dx_nz, dy_nz;
  logic fin, fin_clear, fin_full;
  logic [OBS_CNT_W-1:0] fin_count;

  function automatic logic pt_in_map(input logic signed [COORD_W-1:0] x,
                                     input logic signed [COORD_W-1:0] y,
                                     input logic [SIZE_W-1:0] mw,
                                     input logic [SIZE_W-1:0] mh);
    logic signed [COORD_W-1:0] smw, smh;
    smw = $signed({1'b0, mw});
    smh = $signed({1'b0, mh});
    return (x > 0) && (y > 0) && (x < smw) && (y < smh);
  endfunction

  assign busy = (state != S_IDLE);
  assign count_inc = count + CNT_W'(1);
  assign idx_inc = idx + CNT_W'(1);
  assign table_is_full = (count >= CNT_W'(MAX_OBSTACLES));
  assign in_map_ok = pt_in_map(point_ax, point_ay, extent_x, extent_y)
                  && pt_in_map(point_bx, point_by, extent_x, extent_y);
  assign ram_we = (state == S_IDLE) && start && (action == ACT_ADD) && !table_is_full;
  assign ram_wdata = '{x: rect_x, y: rect_y, w: rect_w, h: rect_h};
  assign last = (idx_inc == count);

  scrc_ram #(
    .WIDTH(RECT_W),
    .DEPTH(MAX_OBSTACLES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[IDX_W-1:0]),
    .wdata(ram_wdata),
    .raddr(idx[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  // shared multiplier and adder
  always_comb begin
    case (step)
      2'd0: begin mul_a = DIFF_W'(dy); mul_b = d_axl; sum_a = p3; sum_b = p1; end
      2'd1: begin mul_a = DIFF_W'(dy); mul_b = d_axr; sum_a = p3; sum_b = p2; end
      2'd2: begin mul_a = DIFF_W'(dx); mul_b = d_tay; sum_a = p4; sum_b = p1; end
      default: begin mul_a = DIFF_W'(dx); mul_b = d_bay; sum_a = p4; sum_b = p2; end
    endcase
    prod = mul_a * mul_b;
    sum = SUM_W'(sum_a) + SUM_W'(sum_b);
  end

  always_comb begin
    dx_nz = (dx != '0);
    dy_nz = (dy != '0);
    dx_pos = dx_nz && !dx[EDGE_W-1];
    dy_pos = dy_nz && !dy[EDGE_W-1];
    top_x = dy_nz && w_nz && t_btw
         && (dy_pos ? (s_ge[0] && s_le[1]) : (s_le[0] && s_ge[1]));
    bot_x = dy_nz && w_nz && b_btw
         && (dy_pos ? (s_ge[2] && s_le[3]) : (s_le[2] && s_ge[3]));
    left_x = dx_nz && h_nz && l_btw
          && (dx_pos ? (s_ge[0] && s_le[2]) : (s_le[0] && s_ge[2]));
    right_x = dx_nz && h_nz && r_btw
           && (dx_pos ? (s_ge[1] && s_le[3]) : (s_le[1] && s_ge[3]));
    rect_hit = cont_hit || top_x || bot_x || left_x || right_x;
  end

  always_comb begin
    state_next = state;
    fin = 1'b0;
    fin_clear = 1'b0;
    fin_full = 1'b0;
    fin_count = OBS_CNT_W'(count);
    case (state)
      S_IDLE: begin
        if (start) begin
          if (action == ACT_ADD) begin
            fin = 1'b1;
            fin_full = table_is_full;
            if (!table_is_full) begin
              fin_count = OBS_CNT_W'(count_inc);
            end
          end else if (!in_map_ok || count == '0) begin
            fin = 1'b1;
            fin_clear = in_map_ok;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: state_next = S_LOAD;
      S_LOAD: state_next = S_DIFF;
      S_DIFF: state_next = S_MUL;
      S_MUL: begin
        if (step == 2'd3) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        if (step == 2'd3) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (rect_hit || last) begin
          state_next = S_IDLE;
          fin = 1'b1;
          fin_clear = !rect_hit;
        end else begin
          state_next = S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      idx <= '0;
      step <= '0;
      done <= 1'b0;
      extent_x <= MAP_SIZE_RESET;
      extent_y <= MAP_SIZE_RESET;
    end else begin
      state <= state_next;
      done <= fin;
      if (ram_we) begin
        count <= count_inc;
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_EXTENT_X: extent_x <= cfg_data;
          REG_EXTENT_Y: extent_y <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_IDLE) begin
        idx <= '0;
      end else if (state == S_EVAL) begin
        idx <= idx_inc;
      end
      if (state == S_MUL || state == S_SUM) begin
        step <= step + 2'd1;
      end else begin
        step <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      path_clear <= fin_clear;
      table_full <= fin_full;
      obstacle_count <= fin_count;
    end
    case (state)
      S_IDLE: begin
        if (start) begin
          ax <= point_ax;
          ay <= point_ay;
          bx <= point_bx;
          by <= point_by;
          dx <= EDGE_W'(point_bx) - EDGE_W'(point_ax);
          dy <= EDGE_W'(point_by) - EDGE_W'(point_ay);
        end
      end
      S_LOAD: begin
        l <= $signed(ram_rdata.x);
        b <= $signed(ram_rdata.y);
        rt <= EDGE_W'($signed(ram_rdata.x)) + EDGE_W'($signed({1'b0, ram_rdata.w}));
        t <= EDGE_W'($signed(ram_rdata.y)) + EDGE_W'($signed({1'b0, ram_rdata.h}));
        w_nz <= (ram_rdata.w != '0);
        h_nz <= (ram_rdata.h != '0);
      end
      S_DIFF: begin
        d_axl <= DIFF_W'(ax) - DIFF_W'(l);
        d_axr <= DIFF_W'(ax) - DIFF_W'(rt);
        d_tay <= DIFF_W'(t) - DIFF_W'(ay);
        d_bay <= DIFF_W'(b) - DIFF_W'(ay);
        cont_hit <= (ax >= l && ax <= rt && ay >= b && ay <= t)
                 || (bx >= l && bx <= rt && by >= b && by <= t);
        t_btw <= (ay <= t && t <= by) || (by <= t && t <= ay);
        b_btw <= (ay <= b && b <= by) || (by <= b && b <= ay);
        l_btw <= (ax <= l && l <= bx) || (bx <= l && l <= ax);
        r_btw <= (ax <= rt && rt <= bx) || (bx <= rt && rt <= ax);
      end
      S_MUL: begin
        case (step)
          2'd0: p1 <= prod;
          2'd1: p2 <= prod;
          2'd2: p3 <= prod;
          default: p4 <= prod;
        endcase
      end
      S_SUM: begin
        s_ge[step] <= !sum[SUM_W-1];
        s_le[step] <= sum[SUM_W-1] || (sum == '0);
      end
      default: ;
    endcase
  end

  `SRCC_ASSERT_NOW(a_done_idle, done, !busy)
  `SRCC_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(MAX_OBSTACLES))
  `SRCC_ASSERT_NOW(a_full_at_cap, done && table_full, count == CNT_W'(MAX_OBSTACLES))
  `SRCC_ASSERT_NEXT(a_add_done, start && !busy && action == ACT_ADD, done && !path_clear)

endmodule

>>> rtl/scrc_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module scrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sim/segment_rect_collision_check_checker.sv
// Checker for the segment-rectangle collision checker: predicts each request and compares results
`timescale 1ns / 1ps
module segment_rect_collision_check_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic                                action,
  input  logic signed [scrc_pkg::COORD_W-1:0] rect_x,
  input  logic signed [scrc_pkg::COORD_W-1:0] rect_y,
  input  logic [scrc_pkg::SIZE_W-1:0]         rect_w,
  input  logic [scrc_pkg::SIZE_W-1:0]         rect_h,
  input  logic signed [scrc_pkg::COORD_W-1:0] point_ax,
  input  logic signed [scrc_pkg::COORD_W-1:0] point_ay,
  input  logic signed [scrc_pkg::COORD_W-1:0] point_bx,
  input  logic signed [scrc_pkg::COORD_W-1:0] point_by,
  input  logic                                cfg_write,
  input  logic [scrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scrc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                done,
  input  logic                                path_clear,
  input  logic                                table_full,
  input  logic [scrc_pkg::OBS_CNT_W-1:0]      obstacle_count,
  output int                                  mismatches,
  output int                                  pending
);

  typedef struct {
    logic                           clear;
    logic                           full;
    logic [scrc_pkg::OBS_CNT_W-1:0] count;
  } segment_verdict_t;

  typedef struct {
    longint lo_x;
    longint lo_y;
    longint hi_x;
    longint hi_y;
  } obstacle_box_t;

  obstacle_box_t    obstacles [scrc_pkg::MAX_OBSTACLES];
  int unsigned      stored = 0;
  longint           map_w = longint'(scrc_pkg::MAP_SIZE_RESET);
  longint           map_h = longint'(scrc_pkg::MAP_SIZE_RESET);
  segment_verdict_t verdict_queue [$];
  int               fail_total = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    fail_total++;
  endtask

  function automatic logic on_map(input longint x, input longint y);
    return x > 0 && y > 0 && x < map_w && y < map_h;
  endfunction

  function automatic logic covers_point(input obstacle_box_t box, input longint x,
                                        input longint y);
    return x >= box.lo_x && x <= box.hi_x && y >= box.lo_y && y <= box.hi_y;
  endfunction

  function automatic logic segments_cross(input longint p1x, input longint p1y,
                                          input longint p2x, input longint p2y,
                                          input longint q1x, input longint q1y,
                                          input longint q2x, input longint q2y);
    longint den;
    longint na;
    longint nb;
    den = (q2y - q1y) * (p2x - p1x) - (q2x - q1x) * (p2y - p1y);
    na = (q2x - q1x) * (p1y - q1y) - (q2y - q1y) * (p1x - q1x);
    nb = (p2x - p1x) * (p1y - q1y) - (p2y - p1y) * (p1x - q1x);
    if (den == 0) return 1'b0;
    if (den < 0) begin
      den = -den;
      na = -na;
      nb = -nb;
    end
    return na >= 0 && na <= den && nb >= 0 && nb <= den;
  endfunction

  function automatic logic box_blocks(input obstacle_box_t box, input longint ax,
                                      input longint ay, input longint bx, input longint by);
    logic hit;
    hit = covers_point(box, ax, ay) || covers_point(box, bx, by);
    hit = hit || segments_cross(ax, ay, bx, by, box.lo_x, box.hi_y, box.hi_x, box.hi_y);
    hit = hit || segments_cross(ax, ay, bx, by, box.lo_x, box.lo_y, box.hi_x, box.lo_y);
    hit = hit || segments_cross(ax, ay, bx, by, box.lo_x, box.hi_y, box.lo_x, box.lo_y);
    hit = hit || segments_cross(ax, ay, bx, by, box.hi_x, box.hi_y, box.hi_x, box.lo_y);
    return hit;
  endfunction

  function automatic segment_verdict_t apply_request();
    segment_verdict_t v;
    longint           ax;
    longint           ay;
    longint           bx;
    longint           by;
    logic             ok;
    int unsigned      i;
    v.clear = 1'b0;
    v.full = 1'b0;
    if (action == scrc_pkg::ACT_ADD) begin
      if (stored < scrc_pkg::MAX_OBSTACLES) begin
        obstacles[stored].lo_x = longint'(rect_x);
        obstacles[stored].lo_y = longint'(rect_y);
        obstacles[stored].hi_x = longint'(rect_x) + longint'(rect_w);
        obstacles[stored].hi_y = longint'(rect_y) + longint'(rect_h);
        stored++;
      end else begin
        v.full = 1'b1;
      end
    end else begin
      ax = longint'(point_ax);
      ay = longint'(point_ay);
      bx = longint'(point_bx);
      by = longint'(point_by);
      ok = on_map(ax, ay) && on_map(bx, by);
      for (i = 0; i < stored; i++) begin
        if (ok && box_blocks(obstacles[i], ax, ay, bx, by)) ok = 1'b0;
      end
      v.clear = ok;
    end
    v.count = scrc_pkg::OBS_CNT_W'(stored);
    return v;
  endfunction

  always @(posedge clk) begin
    segment_verdict_t want;
    if (rst) begin
      stored = 0;
      map_w = longint'(scrc_pkg::MAP_SIZE_RESET);
      map_h = longint'(scrc_pkg::MAP_SIZE_RESET);
      verdict_queue.delete();
    end else begin
      if (done) begin
        if (verdict_queue.size() == 0) begin
          report_mismatch("result with no request, obstacle_count", obstacle_count, -1);
        end else begin
          want = verdict_queue.pop_front();
          if (path_clear !== want.clear) report_mismatch("path_clear", path_clear, want.clear);
          if (table_full !== want.full) report_mismatch("table_full", table_full, want.full);
          if (obstacle_count !== want.count) begin
            report_mismatch("obstacle_count", obstacle_count, want.count);
          end
        end
      end
      if (cfg_write) begin
        if (cfg_index == scrc_pkg::REG_EXTENT_X) begin
          map_w = longint'(cfg_data);
        end else if (cfg_index == scrc_pkg::REG_EXTENT_Y) begin
          map_h = longint'(cfg_data);
        end
      end
      if (start && !busy) verdict_queue.insert(verdict_queue.size(), apply_request());
    end
    mismatches <= fail_total;
    pending <= verdict_queue.size();
  end

endmodule

>>> sim/segment_rect_collision_check_tb.sv
// Testbench top for the segment-rectangle collision checker: stimulus, timeout and verdict
`timescale 1ns / 1ps
module segment_rect_collision_check_tb;

  localparam int LIMIT = 600000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 121;

  logic                                clk;
  logic                                rst;
  logic                                start;
  logic                                busy;
  logic                                action;
  logic signed [scrc_pkg::COORD_W-1:0] rect_x;
  logic signed [scrc_pkg::COORD_W-1:0] rect_y;
  logic [scrc_pkg::SIZE_W-1:0]         rect_w;
  logic [scrc_pkg::SIZE_W-1:0]         rect_h;
  logic signed [scrc_pkg::COORD_W-1:0] point_ax;
  logic signed [scrc_pkg::COORD_W-1:0] point_ay;
  logic signed [scrc_pkg::COORD_W-1:0] point_bx;
  logic signed [scrc_pkg::COORD_W-1:0] point_by;
  logic                                cfg_write;
  logic [scrc_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [scrc_pkg::CFG_DATA_W-1:0]     cfg_data;
  logic                                done;
  logic                                path_clear;
  logic                                table_full;
  logic [scrc_pkg::OBS_CNT_W-1:0]      obstacle_count;
  int                                  mismatches;
  int                                  pending;
  int                                  cycle_count;
  logic                                gaps_on;

  int plan_w [PHASES] = '{64, 32767, 0, 1, 32767, 40};
  int plan_h [PHASES] = '{48, 32767, 32767, 1, 0, 60};

  segment_rect_collision_check u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .rect_x         (rect_x),
    .rect_y         (rect_y),
    .rect_w         (rect_w),
    .rect_h         (rect_h),
    .point_ax       (point_ax),
    .point_ay       (point_ay),
    .point_bx       (point_bx),
    .point_by       (point_by),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .path_clear     (path_clear),
    .table_full     (table_full),
    .obstacle_count (obstacle_count)
  );

  segment_rect_collision_check_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .rect_x         (rect_x),
    .rect_y         (rect_y),
    .rect_w         (rect_w),
    .rect_h         (rect_h),
    .point_ax       (point_ax),
    .point_ay       (point_ay),
    .point_bx       (point_bx),
    .point_by       (point_by),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .path_clear     (path_clear),
    .table_full     (table_full),
    .obstacle_count (obstacle_count),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("segment_rect_collision_check regression: fail");
    $finish;
  end

  task automatic issue_request(input logic act, input logic [15:0] rx, input logic [15:0] ry,
                               input logic [14:0] rw, input logic [14:0] rh,
                               input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] bx, input logic [15:0] by);
    while (gaps_on && $urandom_range(0, 99) < 29) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    rect_x <= rx;
    rect_y <= ry;
    rect_w <= rw;
    rect_h <= rh;
    point_ax <= ax;
    point_ay <= ay;
    point_bx <= bx;
    point_by <= by;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_add(input int x, input int y, input int w, input int h);
    issue_request(scrc_pkg::ACT_ADD, 16'(x), 16'(y), 15'(w), 15'(h), 16'($urandom()),
                  16'($urandom()), 16'($urandom()), 16'($urandom()));
  endtask

  task automatic send_check(input int ax, input int ay, input int bx, input int by);
    issue_request(scrc_pkg::ACT_CHECK, 16'($urandom()), 16'($urandom()), 15'($urandom()),
                  15'($urandom()), 16'(ax), 16'(ay), 16'(bx), 16'(by));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  task automatic set_map(input int w, input int h);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= scrc_pkg::REG_EXTENT_X;
    cfg_data <= scrc_pkg::CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= scrc_pkg::REG_EXTENT_Y;
    cfg_data <= scrc_pkg::CFG_DATA_W'(h);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic int coord_span(input int extent);
    return (extent > 2 && extent - 1 < 80) ? extent - 1 : 80;
  endfunction

  function automatic int boundary_coord(input int extent);
    int pick;
    pick = $urandom_range(0, 3);
    if (pick == 0) return 0;
    if (pick == 1) return 1;
    if (pick == 2) return extent - 1;
    return extent;
  endfunction

  initial begin
    int ph;
    int n;
    int kind;
    int sx;
    int sy;
    int ax;
    int ay;
    int add_pct;
    rst <= 1'b1;
    start <= 1'b0;
    action <= scrc_pkg::ACT_ADD;
    rect_x <= '0;
    rect_y <= '0;
    rect_w <= '0;
    rect_h <= '0;
    point_ax <= '0;
    point_ay <= '0;
    point_bx <= '0;
    point_by <= '0;
    cfg_write <= 1'b0;
    cfg_index <= scrc_pkg::REG_EXTENT_X;
    cfg_data <= '0;
    gaps_on = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty table, reset map size
    send_check(10, 10, 40, 40);
    send_check(0, 10, 20, 20);
    send_check(10, 10, 50, 20);
    send_check(-32768, -32768, 32767, 32767);
    send_check(49, 49, 1, 1);
    send_add(10, 10, 5, 5);
    send_check(5, 12, 20, 12);
    send_check(12, 12, 40, 40);
    send_check(15, 15, 30, 30);
    send_check(8, 13, 12, 17);
    send_check(5, 16, 20, 16);
    send_check(5, 15, 20, 15);
    // degenerate rectangles: a vertical line and a single point
    send_add(30, 30, 0, 8);
    send_check(25, 34, 35, 34);
    send_check(30, 20, 30, 45);
    send_add(40, 5, 0, 0);
    send_check(40, 5, 45, 20);
    send_check(35, 5, 45, 5);
    send_add(-32768, 32767, 32767, 32767);
    send_add(32767, -32768, 0, 32767);
    send_check(1, 1, 49, 1);
    send_check(1, 49, 49, 49);

    for (ph = 0; ph < PHASES; ph++) begin
      set_map(plan_w[ph], plan_h[ph]);
      sx = coord_span(plan_w[ph]);
      sy = coord_span(plan_h[ph]);
      gaps_on = (ph != 1);
      add_pct = (ph == 0) ? 20 : 12;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < add_pct) begin
          if ($urandom_range(0, 9) < 8) begin
            send_add($urandom_range(0, sx), $urandom_range(0, sy), $urandom_range(0, 12),
                     $urandom_range(0, 12));
          end else begin
            send_add($urandom(), $urandom(), $urandom(), $urandom());
          end
        end else begin
          kind = $urandom_range(0, 9);
          ax = $urandom_range(0, sx + 1);
          ay = $urandom_range(0, sy + 1);
          if (kind < 4) begin
            send_check(ax, ay, ax + int'($urandom_range(0, 16)) - 8,
                       ay + int'($urandom_range(0, 16)) - 8);
          end else if (kind < 7) begin
            send_check(ax, ay, $urandom_range(0, sx + 1), $urandom_range(0, sy + 1));
          end else if (kind < 8) begin
            send_check(boundary_coord(plan_w[ph]), ay, ax, boundary_coord(plan_h[ph]));
          end else begin
            send_check($urandom(), $urandom(), $urandom(), $urandom());
          end
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("segment_rect_collision_check regression: pass");
    end else begin
      $display("segment_rect_collision_check regression: fail");
    end
    $finish;
  end

endmodule

>>> segment_rect_collision_check.f
+incdir+rtl
rtl/scrc_pkg.sv
rtl/scrc_ram.sv
rtl/segment_rect_collision_check.sv
sim/segment_rect_collision_check_checker.sv
sim/segment_rect_collision_check_tb.sv
